[sv/tsa_pkg.sv]
// Shared types and constants for the touch sample averager.
// Used by the controller, datapath and top level; depends on nothing.
package tsa_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int PRESS_W    = 16;
	localparam int PROD_W     = 24;
	localparam int SPR_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 12'd4095;
	localparam logic [SPR_W-1:0]     SPR_RESET  = 4'd2;
	localparam logic [PRESS_W-1:0]   THR_RESET  = 16'd15;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_REPORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LIMIT        = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_P_START,
		ST_P_WAIT,
		ST_DECIDE,
		ST_X_START,
		ST_X_WAIT,
		ST_Y_START,
		ST_Y_WAIT,
		ST_A_START,
		ST_A_WAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_PRESS,
		SEL_AVG_X,
		SEL_AVG_Y,
		SEL_AVG_P
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     check;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_capture;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic good;
		logic z1_zero;
		logic div_done;
		logic group_end;
		logic any_good;
		logic out_free;
	} status_t;

endpackage

[sv/tsa_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by the datapath for pressure and average divisions.
module tsa_divider #(
	parameter int DW = 24,
	parameter int VW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;
	logic [VW:0]   diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not go busy after start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider signaled done while still iterating");

endmodule

[sv/tsa_datapath.sv]
// Datapath: input latch, product register, group accumulators, config
// registers, shared divider and output register. Depends on tsa_pkg, tsa_divider.
module tsa_datapath #(
	parameter int MAX_GROUP = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tsa_pkg::cmd_t                   cmd,
	output tsa_pkg::status_t                status,
	input  logic [tsa_pkg::SAMPLE_W-1:0]    x_sample,
	input  logic [tsa_pkg::SAMPLE_W-1:0]    y_sample,
	input  logic [tsa_pkg::SAMPLE_W-1:0]    z1_sample,
	input  logic [tsa_pkg::SAMPLE_W-1:0]    z2_sample,
	input  logic                            sample_ok,
	input  logic                            cfg_wen,
	input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [tsa_pkg::SAMPLE_W-1:0]    pos_x,
	output logic [tsa_pkg::SAMPLE_W-1:0]    pos_y,
	output logic [tsa_pkg::PRESS_W-1:0]     mean_press,
	output logic                            pressed,
	output logic                            report_valid
);
	import tsa_pkg::*;

	localparam int CNT_W   = $clog2(MAX_GROUP + 1);
	localparam int XACC_W  = SAMPLE_W + $clog2(MAX_GROUP);
	localparam int PACC_W  = PRESS_W + $clog2(MAX_GROUP);
	localparam int DIV_W   = (PACC_W > PROD_W) ? PACC_W : PROD_W;
	localparam int CMP_W   = (CNT_W > SPR_W) ? CNT_W : SPR_W;

	logic [SAMPLE_W-1:0] x_q, y_q, z1_q, z2_q;
	logic                ok_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CNT_W-1:0]    grp_cnt_q, good_cnt_q;
	logic [XACC_W-1:0]   x_acc_q, y_acc_q;
	logic [PACC_W-1:0]   p_acc_q;
	logic [SAMPLE_W-1:0] held_x_q, held_y_q;
	logic [SAMPLE_W-1:0] avg_x_q, avg_y_q;
	logic [PRESS_W-1:0]  avg_p_q;
	logic [SPR_W-1:0]    spr_q;
	logic [PRESS_W-1:0]  thr_q;
	logic                out_valid_q;

	logic                good;
	logic [CMP_W-1:0]    group_len;
	logic [DIV_W-1:0]    div_dividend;
	logic [SAMPLE_W-1:0] div_divisor;
	logic                div_done;
	logic [DIV_W-1:0]    div_quotient;

	// A sample counts only if the transfer was clean and both axes are off the rails.
	assign good = ok_q && (x_q != '0) && (x_q != SAMPLE_MAX)
		&& (y_q != '0) && (y_q != SAMPLE_MAX);

	always_comb begin
		if (spr_q == '0) begin
			group_len = CMP_W'(1);
		end else if (CMP_W'(spr_q) > CMP_W'(MAX_GROUP)) begin
			group_len = CMP_W'(MAX_GROUP);
		end else begin
			group_len = CMP_W'(spr_q);
		end
	end

	always_comb begin
		case (cmd.div_sel)
			SEL_PRESS: begin
				div_dividend = DIV_W'(prod_q);
				div_divisor  = z1_q;
			end
			SEL_AVG_X: begin
				div_dividend = DIV_W'(x_acc_q);
				div_divisor  = SAMPLE_W'(good_cnt_q);
			end
			SEL_AVG_Y: begin
				div_dividend = DIV_W'(y_acc_q);
				div_divisor  = SAMPLE_W'(good_cnt_q);
			end
			default: begin
				div_dividend = DIV_W'(p_acc_q);
				div_divisor  = SAMPLE_W'(good_cnt_q);
			end
		endcase
	end

	tsa_divider #(
		.DW(DIV_W),
		.VW(SAMPLE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Input latch and product register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= x_sample;
			y_q  <= y_sample;
			z1_q <= z1_sample;
			z2_q <= z2_sample;
			ok_q <= sample_ok;
		end
		if (cmd.check) begin
			prod_q <= PROD_W'(z2_q) * PROD_W'(x_q);
		end
		if (cmd.div_capture) begin
			case (cmd.div_sel)
				SEL_AVG_X: avg_x_q <= div_quotient[SAMPLE_W-1:0];
				SEL_AVG_Y: avg_y_q <= div_quotient[SAMPLE_W-1:0];
				SEL_AVG_P: avg_p_q <= div_quotient[PRESS_W-1:0];
				default:   ;
			endcase
		end
	end

	// Group state, held position and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q  <= '0;
			good_cnt_q <= '0;
			x_acc_q    <= '0;
			y_acc_q    <= '0;
			p_acc_q    <= '0;
			held_x_q   <= '0;
			held_y_q   <= '0;
			spr_q      <= SPR_RESET;
			thr_q      <= THR_RESET;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_SAMPLES_PER_REPORT: spr_q <= cfg_wdata[SPR_W-1:0];
					REG_PRESS_LIMIT:        thr_q <= cfg_wdata[PRESS_W-1:0];
					default: ;
				endcase
			end
			if (cmd.check) begin
				grp_cnt_q <= grp_cnt_q + 1'b1;
				if (good) begin
					good_cnt_q <= good_cnt_q + 1'b1;
					x_acc_q    <= x_acc_q + XACC_W'(x_q);
					y_acc_q    <= y_acc_q + XACC_W'(y_q);
				end
			end
			if (cmd.div_capture && (cmd.div_sel == SEL_PRESS)) begin
				p_acc_q <= p_acc_q + PACC_W'(div_quotient[PRESS_W-1:0]);
			end
			if (cmd.emit) begin
				grp_cnt_q  <= '0;
				good_cnt_q <= '0;
				x_acc_q    <= '0;
				y_acc_q    <= '0;
				p_acc_q    <= '0;
				if (good_cnt_q != '0) begin
					held_x_q <= avg_x_q;
					held_y_q <= avg_y_q;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.emit || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (good_cnt_q != '0) begin
				pos_x        <= avg_x_q;
				pos_y        <= avg_y_q;
				mean_press   <= avg_p_q;
				pressed      <= avg_p_q > thr_q;
				report_valid <= 1'b1;
			end else begin
				pos_x        <= held_x_q;
				pos_y        <= held_y_q;
				mean_press   <= '0;
				pressed      <= 1'b0;
				report_valid <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign status.good      = good;
	assign status.z1_zero   = (z1_q == '0);
	assign status.div_done  = div_done;
	assign status.group_end = CMP_W'(grp_cnt_q) >= group_len;
	assign status.any_good  = (good_cnt_q != '0);
	assign status.out_free  = !out_valid_q || out_ready;

	a_good_le_group: assert property (@(posedge clk) disable iff (!arst_n)
		good_cnt_q <= grp_cnt_q)
		else $error("good sample count exceeds group count");

endmodule

[sv/tsa_ctrl.sv]
// Controller state machine: sequences accept, pressure divide, group close,
// three average divides and the report hand-off. Depends on tsa_pkg.
module tsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tsa_pkg::status_t status,
	output tsa_pkg::cmd_t    cmd
);
	import tsa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = (status.good && !status.z1_zero) ? ST_P_START : ST_DECIDE;
			end
			ST_P_START: state_d = ST_P_WAIT;
			ST_P_WAIT:  if (status.div_done) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!status.group_end) begin
					state_d = ST_IDLE;
				end else if (status.any_good) begin
					state_d = ST_X_START;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_X_START: state_d = ST_X_WAIT;
			ST_X_WAIT:  if (status.div_done) state_d = ST_Y_START;
			ST_Y_START: state_d = ST_Y_WAIT;
			ST_Y_WAIT:  if (status.div_done) state_d = ST_A_START;
			ST_A_START: state_d = ST_A_WAIT;
			ST_A_WAIT:  if (status.div_done) state_d = ST_EMIT;
			ST_EMIT:    if (status.out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.div_sel  = SEL_PRESS;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK:   cmd.check = 1'b1;
			ST_P_START: cmd.div_start = 1'b1;
			ST_P_WAIT:  cmd.div_capture = status.div_done;
			ST_X_START: begin
				cmd.div_sel   = SEL_AVG_X;
				cmd.div_start = 1'b1;
			end
			ST_X_WAIT: begin
				cmd.div_sel     = SEL_AVG_X;
				cmd.div_capture = status.div_done;
			end
			ST_Y_START: begin
				cmd.div_sel   = SEL_AVG_Y;
				cmd.div_start = 1'b1;
			end
			ST_Y_WAIT: begin
				cmd.div_sel     = SEL_AVG_Y;
				cmd.div_capture = status.div_done;
			end
			ST_A_START: begin
				cmd.div_sel   = SEL_AVG_P;
				cmd.div_start = 1'b1;
			end
			ST_A_WAIT: begin
				cmd.div_sel     = SEL_AVG_P;
				cmd.div_capture = status.div_done;
			end
			ST_EMIT:    cmd.emit = status.out_free;
			default:    ;
		endcase
	end

endmodule

[sv/touch_sample_averager_unit.sv]
// Top level of the touch sample averager: channel ports, controller and datapath.
// Depends on tsa_pkg, tsa_ctrl, tsa_datapath (and through it tsa_divider).
//
//   Channel   Direction  Carries
//   s_axis    in         one conversion set per beat (X, Y, Z1, Z2, transfer ok)
//   m_axis    out        one averaged report per closed group
//   cfg       in         register writes: 0 samples_per_report, 1 pressure limit
//
// A good sample beat with nonzero Z1 is followed by the Z2*X product, a 24-step
// bit-serial divide by Z1, a decide step and a return to idle, and only then is the
// next beat accepted. A dropped sample or a Z1 of zero skips the divide. Closing a
// group adds three divides for the X, Y and pressure averages, plus loading the
// report. All of these divides run on the one shared divider.
// After reset the block is idle and ready at once, with the group cleared and the held
// position at zero. The report sits in an output register, so a stalled m_axis only
// holds the block when a second report is ready to be loaded before the first is taken.
module touch_sample_averager_unit #(
	parameter int MAX_GROUP = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// x_sample[11:0], y_sample[23:12], z1_sample[35:24], z2_sample[47:36]
	input  logic [47:0]                    s_axis_tdata,
	// sample_ok[0]
	input  logic [0:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// pos_x[11:0], pos_y[23:12], mean_press[39:24]
	output logic [39:0]                    m_axis_tdata,
	// pressed[0], report_valid[1]
	output logic [1:0]                     m_axis_tuser,
	input  logic                           cfg_wen,
	input  logic [tsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tsa_pkg::*;

	cmd_t                cmd;
	status_t             status;
	logic [SAMPLE_W-1:0] pos_x, pos_y;
	logic [PRESS_W-1:0]  mean_press;
	logic                pressed, report_valid;

	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tsa_datapath #(
		.MAX_GROUP(MAX_GROUP)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.x_sample     (s_axis_tdata[11:0]),
		.y_sample     (s_axis_tdata[23:12]),
		.z1_sample    (s_axis_tdata[35:24]),
		.z2_sample    (s_axis_tdata[47:36]),
		.sample_ok    (s_axis_tuser[0]),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.mean_press   (mean_press),
		.pressed      (pressed),
		.report_valid (report_valid)
	);

	assign m_axis_tdata = {mean_press, pos_y, pos_x};
	assign m_axis_tuser = {report_valid, pressed};

	// A report without any good sample can never claim a press.
	a_pressed_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("pressed reported without a good sample");

	// An empty group reports zero pressure.
	a_empty_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[39:24] == '0)
		else $error("nonzero pressure in a report with no good sample");

endmodule
